### rtl/ppdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppdc_pkg
// Shared types and constants for the pulse period and duty capture block.
// ----------------------------------------------------------------------------
package ppdc_pkg;

  localparam int TIME_W      = 32;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 2 * TIME_W;

  // in_tuser bit positions
  localparam int IU_LEVEL   = 0;
  localparam int IU_TIMEOUT = 1;
  localparam int IU_OVERRUN = 2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_ROSE = 2'd1,
    ST_FELL = 2'd2
  } edge_state_t;

endpackage : ppdc_pkg
`default_nettype wire

### rtl/pulse_period_duty_capture_top.sv
// Pipeline: an input beat passes the input register, then the result
//   register.
// Throughput: one input beat per cycle while the result register is not stalled;
//   it is the only stall point, and an item that yields no result still uses the input register.
// Reset (rst_n low, synchronous): edge state to idle, measure_duty to 0,
//   both pipeline stages emptied.
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_period_duty_capture_top
// Edge-capture stream in, period and high-width stream out. Captured times
// are wrap-corrected, then a rise/fall tracker forms the differences.
// ----------------------------------------------------------------------------
module pulse_period_duty_capture_top
  import ppdc_pkg::*;
#(
  parameter int COUNTER_BITS = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [TIME_W-1:0]      in_tdata,   // [31:0] capture_time
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,   // [0] level, [1] timeout_pending,
                                                  // [2] capture_overrun
  // result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [31:0] period, [63:32] pulse_width
  output logic                        out_tuser,  // [0] width_valid
  // configuration
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic                   cfg_data    // measure_duty
);

  localparam int CycleBits = TIME_W - COUNTER_BITS;

  logic                    mode_r;
  edge_state_t             state_r, state_nxt;
  logic [TIME_W-1:0]       rise_r, rise_nxt;
  logic [TIME_W-1:0]       fall_r, fall_nxt;

  logic                    s1_valid_r;
  logic [TIME_W-1:0]       s1_time_r;
  logic                    s1_level_r;
  logic                    s1_tmo_r;
  logic                    s1_ovr_r;

  logic                    out_valid_r, out_valid_nxt;
  logic [TIME_W-1:0]       period_r, period_nxt;
  logic [TIME_W-1:0]       width_r, width_nxt;
  logic                    wvalid_r, wvalid_nxt;

  logic                    s2_ready;
  logic                    fire;
  logic                    emit;
  logic                    high;
  logic [CycleBits-1:0]    cyc_dec;
  logic [TIME_W-1:0]       t_adj;

  assign cfg_ready  = 1'b1;
  assign s2_ready   = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || s2_ready;
  assign fire       = s1_valid_r && s2_ready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {width_r, period_r};
  assign out_tuser  = wvalid_r;

  // wrap-cycle correction
  assign cyc_dec = s1_time_r[TIME_W-1:COUNTER_BITS] - CycleBits'(1);
  always_comb begin
    if (s1_tmo_r && s1_time_r[COUNTER_BITS-1]) begin
      t_adj = {cyc_dec, s1_time_r[COUNTER_BITS-1:0]};
    end else begin
      t_adj = s1_time_r;
    end
  end

  assign high = mode_r ? s1_level_r : 1'b1;

  // edge tracker
  always_comb begin
    state_nxt  = state_r;
    rise_nxt   = rise_r;
    fall_nxt   = fall_r;
    emit       = 1'b0;
    period_nxt = rise_r - t_adj;
    width_nxt  = '0;
    wvalid_nxt = 1'b0;
    if (fire) begin
      if (s1_ovr_r) begin
        state_nxt = ST_IDLE;
      end else begin
        case (state_r)
          ST_ROSE: begin
            if (!high) begin
              if (mode_r) begin
                fall_nxt  = t_adj;
                state_nxt = ST_FELL;
              end else begin
                state_nxt = ST_IDLE;
              end
            end else if (mode_r) begin
              rise_nxt = t_adj;
            end else begin
              emit     = 1'b1;
              rise_nxt = t_adj;
            end
          end
          ST_FELL: begin
            if (!high) begin
              state_nxt = ST_IDLE;
            end else begin
              emit       = 1'b1;
              width_nxt  = mode_r ? (rise_r - fall_r) : '0;
              wvalid_nxt = mode_r;
              rise_nxt   = t_adj;
              state_nxt  = ST_ROSE;
            end
          end
          default: begin
            if (high) begin
              rise_nxt  = t_adj;
              state_nxt = ST_ROSE;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s2_ready) begin
      out_valid_nxt = fire && emit;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      state_r     <= ST_IDLE;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    rise_r <= rise_nxt;
    fall_r <= fall_nxt;
    if (in_tvalid && in_tready) begin
      s1_time_r  <= in_tdata;
      s1_level_r <= in_tuser[IU_LEVEL];
      s1_tmo_r   <= in_tuser[IU_TIMEOUT];
      s1_ovr_r   <= in_tuser[IU_OVERRUN];
    end
    if (fire && emit) begin
      period_r <= period_nxt;
      width_r  <= width_nxt;
      wvalid_r <= wvalid_nxt;
    end
  end

endmodule : pulse_period_duty_capture_top
`default_nettype wire

### rtl/ppdc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppdc_checker
// Port-level checks for the pulse period and duty capture block.
// ----------------------------------------------------------------------------
module ppdc_checker
  import ppdc_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tuser
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // no measured width means a zero width field
  a_width_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[OUT_TDATA_W-1:TIME_W] == '0)
    else $error("pulse_width nonzero without width_valid");

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a fresh result follows an accepted input beat, through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result beat without matching input beat");

endmodule : ppdc_checker

bind pulse_period_duty_capture_top ppdc_checker u_ppdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

### dv/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pulse period and duty capture block. A queue
// of edge-capture beats feeds a clocked driver; a clocked monitor checks
// each result beat against a beat-level predictor of the edge tracker.
// Directed edge sequences come first, then random sequences in both modes,
// with random valid/ready gaps outside the last phase and mode changes between phases.
// ----------------------------------------------------------------------------
module tb_top
  import ppdc_pkg::*;
();

  localparam int CNT_W     = 24;
  localparam int WDOG_MAX  = 4000;
  localparam int DRAIN_CYC = 6;

  typedef struct packed {
    logic [TIME_W-1:0]     capture_time;
    logic [IN_TUSER_W-1:0] flags;
  } edge_rec_t;

  typedef struct packed {
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] pulse_width;
    logic              width_valid;
  } span_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  wire logic              in_tready;
  logic [TIME_W-1:0]      in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  wire logic              out_tvalid;
  logic                   out_tready = 1'b0;
  wire logic [OUT_TDATA_W-1:0] out_tdata;
  wire logic              out_tuser;
  logic                   cfg_valid = 1'b0;
  wire logic              cfg_ready;
  logic                   cfg_data = 1'b0;

  pulse_period_duty_capture_top #(
    .COUNTER_BITS(CNT_W)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  edge_rec_t   capture_q[$];
  span_t       expected_spans[$];
  span_t       mon_span;
  edge_rec_t   drv_beat;

  // predictor state
  logic        duty_mode = 1'b0;
  edge_state_t track_state = ST_IDLE;
  logic [31:0] last_rise = '0;
  logic [31:0] last_fall = '0;

  int errors = 0;
  int beats_in = 0;
  int spans_seen = 0;
  int widths_seen = 0;
  int mode_writes = 0;
  int in_gap = 0;
  int out_gap = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %h, expected %h (result beat %0d)",
             field, got, want, spans_seen);
  endtask

  function automatic logic [31:0] wrap_fix(input logic [31:0] ct, input logic timeout);
    logic [31:0] t;
    t = ct;
    if (timeout && ct[CNT_W-1])
      t[31:CNT_W] = ct[31:CNT_W] - (32 - CNT_W)'(1);
    return t;
  endfunction

  function automatic void predict_capture(input edge_rec_t c);
    logic [31:0] t;
    logic        high;
    span_t       s;
    t    = wrap_fix(c.capture_time, c.flags[IU_TIMEOUT]);
    high = duty_mode ? c.flags[IU_LEVEL] : 1'b1;
    if (c.flags[IU_OVERRUN]) begin
      track_state = ST_IDLE;
    end else begin
      case (track_state)
        ST_ROSE: begin
          if (!high) begin
            if (duty_mode) begin
              last_fall   = t;
              track_state = ST_FELL;
            end else begin
              track_state = ST_IDLE;
            end
          end else if (duty_mode) begin
            last_rise = t;
          end else begin
            s.period      = last_rise - t;
            s.pulse_width = '0;
            s.width_valid = 1'b0;
            expected_spans.push_back(s);
            last_rise = t;
          end
        end
        ST_FELL: begin
          if (!high) begin
            track_state = ST_IDLE;
          end else begin
            s.period      = last_rise - t;
            s.pulse_width = duty_mode ? last_rise - last_fall : '0;
            s.width_valid = duty_mode;
            expected_spans.push_back(s);
            last_rise   = t;
            track_state = ST_ROSE;
          end
        end
        default: begin
          if (high) begin
            last_rise   = t;
            track_state = ST_ROSE;
          end else begin
            track_state = ST_IDLE;
          end
        end
      endcase
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_capture(edge_rec_t'({in_tdata, in_tuser}));
        beats_in++;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (capture_q.size() > 0) begin
          if (!quiet && $urandom_range(0, 9) == 0) begin
            in_gap = $urandom_range(1, 13) - 1;
            in_tvalid <= 1'b0;
          end else begin
            drv_beat = capture_q.pop_front();
            in_tdata  <= drv_beat.capture_time;
            in_tuser  <= drv_beat.flags;
            in_tvalid <= 1'b1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        spans_seen++;
        if (expected_spans.size() == 0) begin
          report_mismatch("unexpected result beat", out_tdata[31:0], '0);
        end else begin
          mon_span = expected_spans.pop_front();
          if (mon_span.width_valid)
            widths_seen++;
          if (out_tdata[31:0] !== mon_span.period)
            report_mismatch("period", out_tdata[31:0], mon_span.period);
          if (out_tdata[63:32] !== mon_span.pulse_width)
            report_mismatch("pulse_width", out_tdata[63:32], mon_span.pulse_width);
          if (out_tuser !== mon_span.width_valid)
            report_mismatch("width_valid", {31'b0, out_tuser}, {31'b0, mon_span.width_valid});
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(1, 13) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("Timeout: no beat accepted for %0d cycles", WDOG_MAX);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_capture(input logic [31:0] ct, input logic lvl,
                              input logic timeout, input logic overrun);
    edge_rec_t c;
    c.capture_time         = ct;
    c.flags                = '0;
    c.flags[IU_LEVEL]      = lvl;
    c.flags[IU_TIMEOUT]    = timeout;
    c.flags[IU_OVERRUN]    = overrun;
    capture_q.push_back(c);
  endtask

  task automatic wait_drained();
    while (capture_q.size() > 0 || in_tvalid || expected_spans.size() > 0)
      @(negedge clk);
    // beats without a result may still be in the pipe
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic write_mode(input logic v);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    duty_mode = v;
    mode_writes++;
    @(negedge clk);
  endtask

  task automatic gen_random(input int n);
    logic        lvl;
    logic [31:0] ct;
    lvl = 1'b0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 85)
        lvl = ~lvl;
      else
        lvl = 1'($urandom_range(0, 1));
      ct = $urandom;
      if ($urandom_range(0, 9) == 0)
        ct[CNT_W-1:0] = $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
      push_capture(ct, lvl, $urandom_range(0, 2) == 0, $urandom_range(0, 24) == 0);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // period mode out of reset: every edge counts as a rise
    write_mode(1'b0);
    push_capture(32'hFFFFFFFF, 1'b1, 1'b0, 1'b0);
    push_capture(32'h00000000, 1'b1, 1'b0, 1'b0);
    push_capture(32'h12345678, 1'b0, 1'b0, 1'b0);
    push_capture(32'h00800000, 1'b1, 1'b1, 1'b0);   // cycle byte wraps 0 -> ff
    push_capture(32'h057FFFFF, 1'b1, 1'b1, 1'b0);   // lower half, no fix
    push_capture(32'hABCDEF01, 1'b1, 1'b0, 1'b1);   // overrun
    push_capture(32'h76543210, 1'b1, 1'b0, 1'b0);

    // duty mode, entered while a rise is held
    write_mode(1'b1);
    push_capture(32'h00100000, 1'b0, 1'b0, 1'b0);
    push_capture(32'h000FF000, 1'b0, 1'b0, 1'b0);   // low while fell
    push_capture(32'h000FE000, 1'b0, 1'b0, 1'b0);   // low while idle
    push_capture(32'hA0000000, 1'b1, 1'b0, 1'b0);
    push_capture(32'h90000000, 1'b1, 1'b0, 1'b0);   // rise restarts
    push_capture(32'h8F000000, 1'b0, 1'b0, 1'b0);
    push_capture(32'h80000000, 1'b1, 1'b0, 1'b0);
    push_capture(32'h00000000, 1'b0, 1'b1, 1'b0);
    push_capture(32'hFFFFFFFF, 1'b1, 1'b1, 1'b0);
    push_capture(32'h12121212, 1'b1, 1'b1, 1'b1);   // overrun
    push_capture(32'h00FFFFFF, 1'b1, 1'b1, 1'b0);
    push_capture(32'h00000001, 1'b0, 1'b0, 1'b0);

    // back to period mode from fell
    write_mode(1'b0);
    push_capture(32'h5A5A5A5A, 1'b1, 1'b0, 1'b0);
    push_capture(32'hA5A5A5A5, 1'b0, 1'b1, 1'b0);
    push_capture(32'h00000000, 1'b0, 1'b0, 1'b0);

    write_mode(1'b1);
    gen_random(107);
    write_mode(1'b0);
    gen_random(107);
    write_mode(1'b1);
    gen_random(107);
    write_mode(1'b0);
    quiet = 1'b1;
    gen_random(107);

    wait_drained();

    $display("Summary: %0d capture beats, %0d result beats (%0d with width)",
             beats_in, spans_seen, widths_seen);
    $display("Summary: %0d mode writes across period and duty phases", mode_writes);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule : tb_top
`default_nettype wire
